// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/poi_pkg.sv =====
// shared widths, constants, types and arctangent table for the pose integrator
package poi_pkg;

	localparam int ANGLE_W    = 32;
	localparam int CW         = 34;
	localparam int VEL_W      = 16;
	localparam int DT_W       = 20;
	localparam int POS_W      = 32;
	localparam int Q14_W      = 16;
	localparam int MUL_A_W    = 36;
	localparam int MUL_B_W    = 27;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int PSUM_W     = 50;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 128;
	localparam int ATAN_IDX_W = 5;

	localparam logic signed [CW-1:0]      CORDIC_GAIN    = 34'sd652032874;
	localparam logic signed [MUL_B_W-1:0] INV_TWO_PI_Q28 = 27'sd42722830;

	typedef logic signed [CW-1:0] cval_t;

	typedef struct packed {
		logic  done;
		cval_t cos_v;
		cval_t sin_v;
	} cordic_res_t;

	function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [ANGLE_W-1:0] v;
		case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/poi_mul.sv =====
// shared signed multiplier with registered product
module poi_mul (
	input  logic                                 clk,
	input  logic signed [poi_pkg::MUL_A_W-1:0]   a,
	input  logic signed [poi_pkg::MUL_B_W-1:0]   b,
	output logic signed [poi_pkg::PROD_W-1:0]    prod
);
	import poi_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== rtl/poi_cordic.sv =====
// iterative cordic rotator giving cosine and sine of a binary angle
module poi_cordic #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [poi_pkg::ANGLE_W-1:0]    angle,
	output poi_pkg::cordic_res_t           res
);
	import poi_pkg::*;

	localparam int              IT_W    = $clog2(STAGES);
	localparam logic [IT_W-1:0] LAST_IT = IT_W'(STAGES - 1);
	localparam cval_t           QUARTER = cval_t'(64'sd1 << 30);
	localparam cval_t           HALF    = cval_t'(64'sd1 << 31);

	typedef enum logic [1:0] {C_IDLE, C_ROT, C_DONE} cstate_t;

	cstate_t          state_q;
	cval_t            x_q, y_q, z_q;
	cval_t            cos_q, sin_q;
	logic             flip_q, done_q;
	logic [IT_W-1:0]  it_q;

	cval_t z_in, z_f, x_sh, y_sh, at, nx, ny, nz;
	logic  flip_d;

	always_comb begin
		z_in   = cval_t'(signed'(angle));
		z_f    = z_in;
		flip_d = 1'b0;
		if (z_in > QUARTER) begin
			z_f    = z_in - HALF;
			flip_d = 1'b1;
		end else if (z_in < -QUARTER) begin
			z_f    = z_in + HALF;
			flip_d = 1'b1;
		end
		x_sh = x_q >>> it_q;
		y_sh = y_q >>> it_q;
		at   = cval_t'({2'b00, atan_turn(ATAN_IDX_W'(it_q))});
		if (!z_q[CW-1]) begin
			nx = x_q - y_sh;
			ny = y_q + x_sh;
			nz = z_q - at;
		end else begin
			nx = x_q + y_sh;
			ny = y_q - x_sh;
			nz = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			cos_q   <= '0;
			sin_q   <= '0;
			flip_q  <= 1'b0;
			done_q  <= 1'b0;
			it_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= CORDIC_GAIN;
						y_q     <= '0;
						z_q     <= z_f;
						flip_q  <= flip_d;
						it_q    <= '0;
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					if (it_q == LAST_IT) begin
						state_q <= C_DONE;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				C_DONE: begin
					cos_q   <= flip_q ? -x_q : x_q;
					sin_q   <= flip_q ? -y_q : y_q;
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule

// ===== rtl/planar_odometry_integrator.sv =====
// planar odometry integrator top level: dead reckoning of x, y and heading.
// Each item carries body velocities and a time step; the block rotates the
// velocity by the heading held before the item, adds velocity times time step
// to the saturating positions and the scaled yaw increment to the wrapping
// heading, and returns the new pose with the half-heading quaternion terms.
// Between acceptance and the next ready an item makes two passes through the
// shared cordic rotator and nine steps of the shared multiplier, then waits in
// T_OUT until the output register is free. s_axis_tready is high only while
// no item is in work; a finished result waits in the output register and
// does not hold off acceptance of the next item.
module planar_odometry_integrator #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// vel_x, vel_y, yaw_rate, time_step, zero pad
	input  logic [poi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pos_x, pos_y, heading_angle, quat_z, quat_w
	output logic [poi_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
	import poi_pkg::*;

	localparam logic signed [PSUM_W-1:0] RND14 = PSUM_W'(64'sd1 << 13);
	localparam logic signed [PROD_W:0]   RND32 = (PROD_W + 1)'(64'sd1 << 31);
	localparam logic signed [PROD_W:0]   RND28 = (PROD_W + 1)'(64'sd1 << 27);

	typedef enum logic [3:0] {
		T_IDLE, T_COR1, T_M0, T_M1, T_M2, T_M3, T_M4, T_M5, T_M6, T_M7, T_M8,
		T_HALF, T_COR2, T_OUT
	} state_t;

	function automatic logic signed [POS_W-1:0] sat_add(
		input logic signed [POS_W-1:0] a,
		input logic signed [POS_W-1:0] b
	);
		logic signed [POS_W:0] s;
		s = {a[POS_W-1], a} + {b[POS_W-1], b};
		if (s[POS_W] != s[POS_W-1]) begin
			return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		return s[POS_W-1:0];
	endfunction

	function automatic logic [Q14_W-1:0] to_q14(input cval_t v);
		logic signed [CW:0]        r;
		logic signed [CW-16:0]     q;
		r = {v[CW-1], v} + (CW + 1)'(1 << 15);
		q = r[CW:16];
		if (q[CW-16:Q14_W-1] != {(CW-14-Q14_W){q[CW-16]}}) begin
			return q[CW-16] ? {1'b1, {(Q14_W-1){1'b0}}} : {1'b0, {(Q14_W-1){1'b1}}};
		end
		return q[Q14_W-1:0];
	endfunction

	state_t                      state_q;
	logic signed [VEL_W-1:0]     vel_x_q, vel_y_q, yaw_rate_q;
	logic [DT_W-1:0]             time_step_q;
	cval_t                       c_q, s_q, wx_q, wy_q;
	logic signed [PSUM_W-1:0]    acc_q;
	logic signed [POS_W-1:0]     dx_q, dy_q, x_q, y_q;
	logic [ANGLE_W-1:0]          heading_q;
	logic                        m_valid_q;
	logic [OUT_DATA_W-1:0]       m_data_q;

	logic                        accept;
	logic                        cor_start;
	logic [ANGLE_W-1:0]          cor_angle;
	cordic_res_t                 cor_res;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PSUM_W-1:0]    prod_ps;
	logic signed [PSUM_W-1:0]    psum;
	logic signed [PROD_W:0]      rsum;
	logic                        out_free;

	assign s_axis_tready = (state_q == T_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cor_start     = accept || (state_q == T_HALF);
	assign cor_angle     = (state_q == T_HALF) ? {1'b0, heading_q[ANGLE_W-1:1]} : heading_q;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign prod_ps       = prod[PSUM_W-1:0];

	poi_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.res    (cor_res)
	);

	poi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			T_M0: begin
				mul_a = MUL_A_W'(c_q);
				mul_b = MUL_B_W'(vel_x_q);
			end
			T_M1: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(vel_y_q);
			end
			T_M2: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(vel_x_q);
			end
			T_M3: begin
				mul_a = MUL_A_W'(c_q);
				mul_b = MUL_B_W'(vel_y_q);
			end
			T_M4: begin
				mul_a = MUL_A_W'(wx_q);
				mul_b = MUL_B_W'({1'b0, time_step_q});
			end
			T_M5: begin
				mul_a = MUL_A_W'(wy_q);
				mul_b = MUL_B_W'({1'b0, time_step_q});
			end
			T_M6: begin
				mul_a = MUL_A_W'(yaw_rate_q);
				mul_b = MUL_B_W'({1'b0, time_step_q});
			end
			T_M7: begin
				mul_a = prod[MUL_A_W-1:0];
				mul_b = INV_TWO_PI_Q28;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		psum = (state_q == T_M2) ? acc_q - prod_ps : acc_q + prod_ps;
		rsum = {prod[PROD_W-1], prod} + ((state_q == T_M8) ? RND28 : RND32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			yaw_rate_q  <= '0;
			time_step_q <= '0;
			c_q         <= '0;
			s_q         <= '0;
			wx_q        <= '0;
			wy_q        <= '0;
			acc_q       <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			heading_q   <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && (state_q != T_OUT)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						vel_x_q     <= s_axis_tdata[15:0];
						vel_y_q     <= s_axis_tdata[31:16];
						yaw_rate_q  <= s_axis_tdata[47:32];
						time_step_q <= s_axis_tdata[67:48];
						state_q     <= T_COR1;
					end
				end
				T_COR1: begin
					if (cor_res.done) begin
						c_q     <= cor_res.cos_v;
						s_q     <= cor_res.sin_v;
						state_q <= T_M0;
					end
				end
				T_M0: state_q <= T_M1;
				T_M1: begin
					acc_q   <= prod_ps + RND14;
					state_q <= T_M2;
				end
				T_M2: begin
					wx_q    <= psum[CW+13:14];
					state_q <= T_M3;
				end
				T_M3: begin
					acc_q   <= prod_ps + RND14;
					state_q <= T_M4;
				end
				T_M4: begin
					wy_q    <= psum[CW+13:14];
					state_q <= T_M5;
				end
				T_M5: begin
					dx_q    <= rsum[PROD_W:32];
					state_q <= T_M6;
				end
				T_M6: begin
					dy_q    <= rsum[PROD_W:32];
					x_q     <= sat_add(x_q, dx_q);
					state_q <= T_M7;
				end
				T_M7: begin
					y_q     <= sat_add(y_q, dy_q);
					state_q <= T_M8;
				end
				T_M8: begin
					heading_q <= heading_q + rsum[ANGLE_W+27:28];
					state_q   <= T_HALF;
				end
				T_HALF: state_q <= T_COR2;
				T_COR2: begin
					if (cor_res.done) begin
						c_q     <= cor_res.cos_v;
						s_q     <= cor_res.sin_v;
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						m_data_q  <= {to_q14(c_q), to_q14(s_q), heading_q, y_q, x_q};
						m_valid_q <= 1'b1;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/poi_checker.sv =====
// port-level checks for the pose integrator, bound to the top level
`include "assert_macros.svh"

module poi_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [poi_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import poi_pkg::*;

	logic in_acc;
	logic out_stall;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(m_axis_tdata))
	`ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_acc, !s_axis_tready)
	`ASSERT_ALWAYS(a_result_after_work, clk, arst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

// ===== dv/tb_top.sv =====
// testbench for the planar odometry integrator: queued stimulus, pose predictor and checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint RAD_TO_TURN_Q28 = 42722830;
	localparam logic [19:0] DT_MAX = 20'hFFFFF;
	localparam int SAT_RUN = 300;
	localparam int RAND_ITEMS = 780;

	typedef struct {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] yaw_rate;
		logic [19:0]        time_step;
		bit                 drain;
	} motion_t;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading_angle;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// vel_x, vel_y, yaw_rate, time_step, zero pad
	logic [poi_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// pos_x, pos_y, heading_angle, quat_z, quat_w
	logic [poi_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic in_taken = 1'b0;

	motion_t motion_q [$];
	pose_t   pose_due [$];
	int n_total = 1;
	int n_acc = 0;
	int n_err = 0;
	int snd_idle;
	int rcv_idle;

	logic signed [31:0] x_pos = '0;
	logic signed [31:0] y_pos = '0;
	logic [31:0]        hdg = '0;

	planar_odometry_integrator #(
		.CORDIC_STAGES(STAGES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic longint atan_q30(input int i);
		case (i)
			0:  return 64'h20000000;
			1:  return 64'h12E4051E;
			2:  return 64'h09FB385B;
			3:  return 64'h051111D4;
			4:  return 64'h028B0D43;
			5:  return 64'h0145D7E1;
			6:  return 64'h00A2F61E;
			7:  return 64'h00517C55;
			8:  return 64'h0028BE53;
			9:  return 64'h00145F2F;
			10: return 64'h000A2F98;
			11: return 64'h000517CC;
			12: return 64'h00028BE6;
			13: return 64'h000145F3;
			14: return 64'h0000A2FA;
			15: return 64'h0000517D;
			16: return 64'h000028BE;
			17: return 64'h0000145F;
			18: return 64'h00000A30;
			19: return 64'h00000518;
			20: return 64'h0000028C;
			21: return 64'h00000146;
			22: return 64'h000000A3;
			23: return 64'h00000051;
			default: return 64'h0;
		endcase
	endfunction

	// add half then floor
	function automatic longint rnd_shr(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] to_q14(input longint v);
		longint r;
		r = rnd_shr(v, 16);
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// quarter-turn fold, then fixed-length rotation in q1.30
	function automatic void sin_cos_q30(input logic [31:0] ang, output longint c,
			output longint s);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit flip;
		z = longint'($signed(ang));
		flip = 1'b0;
		x = GAIN_Q30;
		y = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1'b1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_q30(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_q30(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	function automatic pose_t advance_pose(input logic [poi_pkg::IN_DATA_W-1:0] d);
		longint vx;
		longint vy;
		longint wz;
		longint dt;
		longint c;
		longint s;
		longint wx;
		longint wy;
		longint dh;
		pose_t p;
		vx = longint'($signed(d[15:0]));
		vy = longint'($signed(d[31:16]));
		wz = longint'($signed(d[47:32]));
		dt = longint'({44'd0, d[67:48]});
		sin_cos_q30(hdg, c, s);
		wx = rnd_shr(vx * c - vy * s, 14);
		wy = rnd_shr(vx * s + vy * c, 14);
		x_pos = sat32(longint'(x_pos) + rnd_shr(wx * dt, 32));
		y_pos = sat32(longint'(y_pos) + rnd_shr(wy * dt, 32));
		dh = rnd_shr(wz * dt * RAD_TO_TURN_Q28, 28);
		hdg = hdg + dh[31:0];
		sin_cos_q30({1'b0, hdg[31:1]}, c, s);
		p.pos_x = x_pos;
		p.pos_y = y_pos;
		p.heading_angle = hdg;
		p.quat_z = to_q14(s);
		p.quat_w = to_q14(c);
		return p;
	endfunction

	function automatic logic [poi_pkg::IN_DATA_W-1:0] pack_motion(input motion_t m);
		return {4'd0, m.time_step, m.yaw_rate, m.vel_y, m.vel_x};
	endfunction

	function automatic motion_t mk_motion(input int vx, input int vy, input int wz,
			input int unsigned dt, input bit drain);
		motion_t m;
		m.vel_x = vx[15:0];
		m.vel_y = vy[15:0];
		m.yaw_rate = wz[15:0];
		m.time_step = dt[19:0];
		m.drain = drain;
		return m;
	endfunction

	function automatic int edge_val();
		case ($urandom_range(4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic motion_t rand_motion();
		int unsigned dt;
		case ($urandom_range(7))
			0, 1: begin
				return mk_motion($urandom, $urandom, $urandom, $urandom, 1'b0);
			end
			2: begin
				case ($urandom_range(2))
					0: dt = 0;
					1: dt = 1;
					default: dt = DT_MAX;
				endcase
				return mk_motion(edge_val(), edge_val(), edge_val(), dt, 1'b0);
			end
			default: begin
				dt = ($urandom_range(9) == 0) ? 0 : $urandom_range(65535);
				return mk_motion(int'($urandom_range(8192)) - 4096,
					int'($urandom_range(8192)) - 4096,
					int'($urandom_range(16384)) - 8192, dt, 1'b0);
			end
		endcase
	endfunction

	task automatic add_motion(input motion_t m);
		motion_q.insert(motion_q.size(), m);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			n_err++;
		end
	endtask

	always_comb begin
		if (n_acc < n_total / 3) begin
			snd_idle = 21;
			rcv_idle = 69;
		end else if (n_acc < 2 * n_total / 3) begin
			snd_idle = 69;
			rcv_idle = 21;
		end else begin
			snd_idle = 0;
			rcv_idle = 0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// hold the item until it is taken
			end else if (motion_q.size() != 0 &&
					!(motion_q[0].drain && pose_due.size() != 0) &&
					$urandom_range(99) >= snd_idle) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pack_motion(motion_q.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin : monitor
		pose_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pose_due.size() == 0) begin
					$error("pose result with no item pending");
					n_err++;
				end else begin
					want = pose_due.pop_front();
					check_field("pos_x", want.pos_x, m_axis_tdata[31:0]);
					check_field("pos_y", want.pos_y, m_axis_tdata[63:32]);
					check_field("heading_angle", want.heading_angle, m_axis_tdata[95:64]);
					check_field("quat_z", {16'd0, want.quat_z}, {16'd0, m_axis_tdata[111:96]});
					check_field("quat_w", {16'd0, want.quat_w}, {16'd0, m_axis_tdata[127:112]});
				end
			end
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				pose_due.insert(pose_due.size(), advance_pose(s_axis_tdata));
				n_acc++;
			end
		end
	end

	initial begin
		// straight run at zero heading with full-scale velocities
		for (int i = 0; i < SAT_RUN; i++)
			add_motion(mk_motion(32767, -32768, 0, DT_MAX, 1'b0));
		add_motion(mk_motion(0, 0, 0, 0, 1'b1));
		add_motion(mk_motion(-32768, 32767, 0, DT_MAX, 1'b0));
		add_motion(mk_motion(-32768, 32767, 0, DT_MAX, 1'b0));
		add_motion(mk_motion(32767, 32767, 32767, 0, 1'b0));
		add_motion(mk_motion(0, 0, 32767, DT_MAX, 1'b0));
		add_motion(mk_motion(0, 0, -32768, DT_MAX, 1'b0));
		add_motion(mk_motion(0, 0, 1, 1, 1'b0));
		add_motion(mk_motion(0, 0, -1, 1, 1'b0));
		add_motion(mk_motion(32767, -32768, 12345, 52429, 1'b0));
		add_motion(mk_motion(-32768, -32768, -32768, DT_MAX, 1'b0));
		add_motion(mk_motion(-1, -1, -1, DT_MAX, 1'b0));
		add_motion(mk_motion(1, 1, 1, 1, 1'b0));
		// heading walks in quarter and half turns across the fold boundaries
		for (int i = 0; i < 4; i++)
			add_motion(mk_motion(20000, -7000, 6434, DT_MAX, 1'b0));
		add_motion(mk_motion(-9000, 15000, 12868, DT_MAX, 1'b0));
		add_motion(mk_motion(4096, 4096, -12868, DT_MAX, 1'b0));
		for (int i = 0; i < RAND_ITEMS; i++)
			add_motion(rand_motion());
		motion_q[SAT_RUN + 40].drain = 1'b1;
		n_total = motion_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (motion_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (pose_due.size() != 0)
			@(posedge clk);
		repeat (2 * STAGES + 32) @(posedge clk);
		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/poi_pkg.sv
rtl/poi_mul.sv
rtl/poi_cordic.sv
rtl/planar_odometry_integrator.sv
rtl/poi_checker.sv
dv/tb_top.sv
